@@ sv/lps_pkg.sv @@
// Shared types, codes and the init command table for the LCD page refresh sequencer.
`default_nettype none

package lps_pkg;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_WRITE    = 3'd1;
    localparam logic [2:0] CMD_REFRESH  = 3'd2;
    localparam logic [2:0] CMD_INIT     = 3'd3;
    localparam logic [2:0] CMD_CONTRAST = 3'd4;

    localparam logic [1:0] REG_COLUMN_LOW = 2'd0;
    localparam logic [1:0] REG_PAD_MODE   = 2'd1;
    localparam logic [1:0] REG_CONTRAST   = 2'd2;

    localparam logic [7:0] LCD_PAGE_BASE   = 8'hB0;
    localparam logic [7:0] LCD_COLUMN_HIGH = 8'h10;
    localparam logic [7:0] LCD_CONTRAST    = 8'h81;
    localparam logic [7:0] LCD_NOP         = 8'hE3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [3:0] column_low;
        logic       pad_mode;
        logic [5:0] contrast;
    } cfg_t;

    typedef struct packed {
        logic       data_mode;
        logic [7:0] cmd_byte;
        logic       use_mem;
        logic       last;
    } desc_t;

    typedef struct packed {
        logic       data_mode;
        logic [7:0] bus_byte;
        logic       sequence_end;
    } result_t;

    function automatic logic [7:0] init_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'hE2;
            5'd1:    b = 8'hAE;
            5'd2:    b = 8'hA1;
            5'd3:    b = 8'hA6;
            5'd4:    b = 8'hA4;
            5'd5:    b = 8'hA2;
            5'd6:    b = 8'hC0;
            5'd7:    b = 8'h2F;
            5'd8:    b = 8'h25;
            5'd9:    b = 8'h81;
            5'd10:   b = 8'h22;
            5'd11:   b = 8'hAF;
            default: b = LCD_NOP;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ sv/lps_item_if.sv @@
// Input channel: command transactions with framebuffer write payload.
`default_nettype none

interface lps_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [9:0] buffer_address;
    logic [7:0] buffer_data;

    modport source (output valid, output command, output buffer_address, output buffer_data,
                    input ready);
    modport sink   (input valid, input command, input buffer_address, input buffer_data,
                    output ready);
endinterface

`default_nettype wire

@@ sv/lps_result_if.sv @@
// Output channel: one LCD bus transfer per transaction.
`default_nettype none

interface lps_result_if;
    logic       valid;
    logic       ready;
    logic       data_mode;
    logic [7:0] bus_byte;
    logic       sequence_end;

    modport source (output valid, output data_mode, output bus_byte, output sequence_end,
                    input ready);
    modport sink   (input valid, input data_mode, input bus_byte, input sequence_end,
                    output ready);
endinterface

`default_nettype wire

@@ sv/lps_front.sv @@
// Front end: decodes commands, runs the sequence counters, issues framebuffer reads.
`default_nettype none

module lps_front #(
    parameter int PANEL_WIDTH = 128,
    parameter int PAGE_COUNT  = 8,
    parameter int INIT_LENGTH = 12,
    parameter int AW          = 10
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                accept,
    input  wire  [2:0]         command,
    input  lps_pkg::cfg_t      cfg,
    output logic               write_en,
    output logic               read_en,
    output logic [AW-1:0]      read_addr,
    output logic               desc_valid,
    output lps_pkg::desc_t     desc
);
    import lps_pkg::*;

    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int STEP_RW = $clog2(PANEL_WIDTH + 8);
    localparam int STEP_IW = $clog2(INIT_LENGTH + 1);
    localparam int STEP_W  = (STEP_RW > STEP_IW) ? STEP_RW : STEP_IW;

    localparam logic [1:0] KIND_IDLE     = 2'd0;
    localparam logic [1:0] KIND_REFRESH  = 2'd1;
    localparam logic [1:0] KIND_INIT     = 2'd2;
    localparam logic [1:0] KIND_CONTRAST = 2'd3;

    logic [1:0]        kind_reg, kind_next, kind_eff;
    logic [PAGE_W-1:0] page_reg, page_next, page_eff;
    logic [STEP_W-1:0] step_reg, step_next, step_eff;
    logic              desc_valid_reg, produce;
    desc_t             desc_reg, desc_next;

    logic [STEP_W:0]   step_p1, row_len;
    logic [STEP_W-1:0] data_pos, pad_w, col;
    logic              page_done, in_row, last_page;

    assign write_en = accept && (command == CMD_WRITE);
    assign read_en  = accept;

    always_comb
    begin
        kind_eff = kind_reg;
        page_eff = page_reg;
        step_eff = step_reg;
        if (kind_reg == KIND_IDLE)
        begin
            page_eff = '0;
            step_eff = '0;
            case (command)
                CMD_REFRESH:  kind_eff = KIND_REFRESH;
                CMD_INIT:     kind_eff = KIND_INIT;
                CMD_CONTRAST: kind_eff = KIND_CONTRAST;
                default:      kind_eff = KIND_IDLE;
            endcase
        end
    end

    // refresh row geometry, row length taken from the live pad setting
    assign step_p1   = {1'b0, step_eff} + (STEP_W+1)'(1);
    assign row_len   = (STEP_W+1)'(PANEL_WIDTH + 3) + (cfg.pad_mode ? (STEP_W+1)'(4) : '0);
    assign page_done = step_p1 >= row_len;
    assign last_page = 32'(page_eff) == PAGE_COUNT - 1;
    assign data_pos  = step_eff - STEP_W'(3);
    assign pad_w     = cfg.pad_mode ? STEP_W'(2) : '0;
    assign in_row    = (data_pos >= pad_w) && (data_pos < pad_w + STEP_W'(PANEL_WIDTH));
    assign col       = data_pos - pad_w;
    assign read_addr = AW'(32'(page_eff) * 32'(PANEL_WIDTH) + 32'(col));

    always_comb
    begin
        desc_next = '0;
        produce   = 1'b0;
        kind_next = kind_eff;
        page_next = page_eff;
        step_next = step_eff;
        case (kind_eff)
            KIND_REFRESH:
            begin
                produce        = 1'b1;
                desc_next.last = page_done && last_page;
                if (step_eff == STEP_W'(0))
                begin
                    desc_next.cmd_byte = {4'b0, cfg.column_low};
                end
                else if (step_eff == STEP_W'(1))
                begin
                    desc_next.cmd_byte = LCD_COLUMN_HIGH;
                end
                else if (step_eff == STEP_W'(2))
                begin
                    desc_next.cmd_byte = LCD_PAGE_BASE | {4'b0, 4'(page_eff)};
                end
                else
                begin
                    desc_next.data_mode = 1'b1;
                    desc_next.use_mem   = in_row;
                end
                if (desc_next.last)
                begin
                    kind_next = KIND_IDLE;
                    page_next = '0;
                    step_next = '0;
                end
                else if (page_done)
                begin
                    page_next = page_eff + PAGE_W'(1);
                    step_next = '0;
                end
                else
                begin
                    step_next = step_eff + STEP_W'(1);
                end
            end
            KIND_INIT:
            begin
                produce            = 1'b1;
                desc_next.cmd_byte = init_byte(5'(step_eff));
                desc_next.last     = 32'(step_eff) + 1 >= INIT_LENGTH;
                if (desc_next.last)
                begin
                    kind_next = KIND_IDLE;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_eff + STEP_W'(1);
                end
            end
            KIND_CONTRAST:
            begin
                produce = 1'b1;
                if (step_eff == '0)
                begin
                    desc_next.cmd_byte = LCD_CONTRAST;
                    step_next          = STEP_W'(1);
                end
                else
                begin
                    desc_next.cmd_byte = {2'b0, cfg.contrast};
                    desc_next.last     = 1'b1;
                    kind_next          = KIND_IDLE;
                    step_next          = '0;
                end
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= KIND_IDLE;
            page_reg       <= '0;
            step_reg       <= '0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            desc_valid_reg <= accept && produce;
            if (accept)
            begin
                kind_reg <= kind_next;
                page_reg <= page_next;
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg <= desc_next;
        end
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

`default_nettype wire

@@ sv/lps_store.sv @@
// Framebuffer memory with post-reset clearing sweep and write-first registered read.
`default_nettype none

module lps_store #(
    parameter int STORE_SIZE = 1024,
    parameter int AW         = 10
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            item_we,
    input  wire  [9:0]     item_waddr,
    input  wire  [7:0]     item_wdata,
    input  wire            rd_en,
    input  wire  [AW-1:0]  rd_addr,
    output logic [7:0]     rd_data,
    output logic           clearing
);
    localparam int CW = ((AW > 10) ? AW : 10) + 1;

    logic [7:0]    mem [STORE_SIZE];
    logic [7:0]    rd_data_reg;
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    always_comb
    begin
        if (clearing_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = item_we && (CW'(item_waddr) < CW'(STORE_SIZE));
            waddr = AW'(item_waddr);
            wdata = item_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (32'(clr_addr_reg) == STORE_SIZE - 1)
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            // a write in the same transaction is seen by the read
            rd_data_reg <= (we && (waddr == rd_addr)) ? wdata : mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

@@ sv/lps_back.sv @@
// Back end: merges read data into the transfer and queues it toward the output channel.
`default_nettype none

module lps_back (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              desc_valid,
    input  lps_pkg::desc_t                   desc,
    input  wire  [7:0]                       rd_data,
    output logic [lps_pkg::QUEUE_CNT_W-1:0]  count,
    lps_result_if.source                     results
);
    import lps_pkg::*;

    result_t                q [QUEUE_DEPTH];
    result_t                head, push_item;
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   push, pop;

    assign push_item.data_mode    = desc.data_mode;
    assign push_item.bus_byte     = desc.use_mem ? rd_data : desc.cmd_byte;
    assign push_item.sequence_end = desc.last;

    assign push = desc_valid;
    assign pop  = results.valid && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q[wr_ptr_reg] <= push_item;
        end
    end

    assign head                 = q[rd_ptr_reg];
    assign results.valid        = count_reg != '0;
    assign results.data_mode    = head.data_mode;
    assign results.bus_byte     = head.bus_byte;
    assign results.sequence_end = head.sequence_end;
    assign count                = count_reg;

endmodule

`default_nettype wire

@@ sv/lcd_page_refresh_sequencer.sv @@
// Top level of the LCD page refresh sequencer.
`default_nettype none

// Drives a page-organized LCD with at most one bus transfer per command transaction: init
// sequence, contrast pair, or full framebuffer refresh (3 header commands plus the row per
// page). One transaction is taken per cycle unless stalled; its transfer is registered, then
// held in a four-entry queue toward the result channel. The block stalls when the queued
// transfers plus the one in flight fill the queue. After reset the framebuffer memory is
// cleared one byte per cycle, PANEL_WIDTH * PAGE_COUNT bytes (1024 at the defaults); items
// are not accepted until the sweep ends, while configuration writes are.
module lcd_page_refresh_sequencer #(
    parameter int PANEL_WIDTH = 128,
    parameter int PAGE_COUNT  = 8,
    parameter int INIT_LENGTH = 12
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_write,
    input  wire  [1:0]  cfg_index,
    input  wire  [5:0]  cfg_data,
    lps_item_if.sink    items,
    lps_result_if.source results
);
    import lps_pkg::*;

    localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
    localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    logic [3:0]             column_low_reg;
    logic                   pad_mode_reg;
    logic [5:0]             contrast_reg;
    cfg_t                   cfg;
    logic                   accept, write_en, read_en, desc_valid, clearing;
    logic [AW-1:0]          read_addr;
    logic [7:0]             rd_data;
    logic [QUEUE_CNT_W-1:0] q_count;
    desc_t                  desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_low_reg <= 4'd4;
            pad_mode_reg   <= 1'b0;
            contrast_reg   <= 6'd34;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COLUMN_LOW: column_low_reg <= cfg_data[3:0];
                REG_PAD_MODE:   pad_mode_reg   <= cfg_data[0];
                REG_CONTRAST:   contrast_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg.column_low = column_low_reg;
    assign cfg.pad_mode   = pad_mode_reg;
    assign cfg.contrast   = contrast_reg;

    // room for the transaction in flight plus the new one
    assign items.ready = !clearing &&
                         ((q_count + QUEUE_CNT_W'(desc_valid)) < QUEUE_CNT_W'(QUEUE_DEPTH));
    assign accept      = items.valid && items.ready;

    lps_front #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PAGE_COUNT  (PAGE_COUNT),
        .INIT_LENGTH (INIT_LENGTH),
        .AW          (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (items.command),
        .cfg        (cfg),
        .write_en   (write_en),
        .read_en    (read_en),
        .read_addr  (read_addr),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    lps_store #(
        .STORE_SIZE (STORE_SIZE),
        .AW         (AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_we    (write_en),
        .item_waddr (items.buffer_address),
        .item_wdata (items.buffer_data),
        .rd_en      (read_en),
        .rd_addr    (read_addr),
        .rd_data    (rd_data),
        .clearing   (clearing)
    );

    lps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .rd_data    (rd_data),
        .count      (q_count),
        .results    (results)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_desc_origin: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> $past(items.valid && items.ready))
        else $error("transfer without an accepted transaction");

    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && (q_count == QUEUE_CNT_W'(1)) && !desc_valid)
        |=> !results.valid)
        else $error("queue shows data after draining");

endmodule

`default_nettype wire
